@@ design/sensor_voltage_table_linearizer_core_macros.svh @@
// Assertion macros used by the linearizer core.
`ifndef SENSOR_VOLTAGE_TABLE_LINEARIZER_CORE_MACROS_SVH
`define SENSOR_VOLTAGE_TABLE_LINEARIZER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SVTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/svtl_pkg.sv @@
// Package with the breakpoint table, widths, state type and divider request type.
`default_nettype none

package svtl_pkg;

    localparam int MV_W     = 11;
    localparam int TEMP_W   = 17;
    localparam int ROM_SIZE = 201;
    localparam int TOP_TEMP = 150;

    // Sensor voltage at each whole degree, from 150 C down to -50 C.
    localparam logic [MV_W-1:0] VOLT_ROM [ROM_SIZE] = '{
        11'd301,  11'd310,  11'd319,  11'd328,  11'd337,  11'd346,  11'd354,  11'd363,
        11'd372,  11'd381,  11'd390,  11'd399,  11'd408,  11'd416,  11'd425,  11'd434,
        11'd443,  11'd452,  11'd460,  11'd469,  11'd478,  11'd487,  11'd495,  11'd504,
        11'd513,  11'd521,  11'd530,  11'd539,  11'd547,  11'd556,  11'd565,  11'd573,
        11'd582,  11'd591,  11'd599,  11'd608,  11'd617,  11'd625,  11'd634,  11'd642,
        11'd651,  11'd660,  11'd668,  11'd677,  11'd685,  11'd694,  11'd702,  11'd711,
        11'd720,  11'd728,  11'd737,  11'd745,  11'd754,  11'd762,  11'd771,  11'd779,
        11'd788,  11'd797,  11'd805,  11'd814,  11'd822,  11'd831,  11'd839,  11'd848,
        11'd856,  11'd865,  11'd873,  11'd881,  11'd890,  11'd898,  11'd907,  11'd915,
        11'd924,  11'd932,  11'd941,  11'd949,  11'd957,  11'd966,  11'd974,  11'd983,
        11'd991,  11'd1000, 11'd1008, 11'd1017, 11'd1025, 11'd1034, 11'd1042, 11'd1051,
        11'd1059, 11'd1067, 11'd1076, 11'd1084, 11'd1093, 11'd1101, 11'd1109, 11'd1118,
        11'd1126, 11'd1134, 11'd1143, 11'd1151, 11'd1159, 11'd1167, 11'd1176, 11'd1184,
        11'd1192, 11'd1201, 11'd1209, 11'd1217, 11'd1225, 11'd1234, 11'd1242, 11'd1250,
        11'd1258, 11'd1267, 11'd1275, 11'd1283, 11'd1291, 11'd1299, 11'd1308, 11'd1316,
        11'd1324, 11'd1332, 11'd1340, 11'd1348, 11'd1356, 11'd1365, 11'd1373, 11'd1381,
        11'd1389, 11'd1397, 11'd1405, 11'd1413, 11'd1421, 11'd1430, 11'd1438, 11'd1446,
        11'd1454, 11'd1462, 11'd1470, 11'd1478, 11'd1486, 11'd1494, 11'd1502, 11'd1511,
        11'd1519, 11'd1527, 11'd1535, 11'd1543, 11'd1551, 11'd1559, 11'd1567, 11'd1575,
        11'd1583, 11'd1591, 11'd1599, 11'd1607, 11'd1615, 11'd1623, 11'd1631, 11'd1639,
        11'd1648, 11'd1656, 11'd1663, 11'd1671, 11'd1679, 11'd1687, 11'd1695, 11'd1703,
        11'd1711, 11'd1719, 11'd1727, 11'd1735, 11'd1743, 11'd1751, 11'd1759, 11'd1767,
        11'd1775, 11'd1783, 11'd1790, 11'd1798, 11'd1806, 11'd1814, 11'd1822, 11'd1830,
        11'd1838, 11'd1845, 11'd1853, 11'd1861, 11'd1869, 11'd1877, 11'd1885, 11'd1892,
        11'd1900, 11'd1908, 11'd1915, 11'd1921, 11'd1928, 11'd1935, 11'd1942, 11'd1949,
        11'd1955
    };

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic            start;
        logic [MV_W-1:0] num;
        logic [MV_W-1:0] den;
    } t_div_req;

    function automatic logic [MV_W-1:0] rom_mv(input logic [7:0] idx);
        logic [MV_W-1:0] v;
        v = '0;
        if (int'(idx) < ROM_SIZE) begin
            v = VOLT_ROM[idx];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/svtl_stream_if.sv @@
// Valid/ready channel interfaces for the voltage input and the temperature output.
`default_nettype none

interface svtl_mv_if import svtl_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] millivolts;

    modport source (output valid, output millivolts, input ready);
    modport sink   (input valid, input millivolts, output ready);
endinterface

interface svtl_temp_if import svtl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_q8;

    modport source (output valid, output temperature_q8, input ready);
    modport sink   (input valid, input temperature_q8, output ready);
endinterface

`default_nettype wire

@@ design/svtl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module svtl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 201
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/svtl_div.sv @@
// Bit-serial restoring divider that returns ceil(num * 2^FRAC_BITS / den) for num < den.
`default_nettype none

module svtl_div import svtl_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_div_req           i_req,
    output logic                    o_done,
    output logic [FRAC_BITS:0]      o_frac
);

    localparam int QW = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int CW = (FRAC_BITS > 0) ? $clog2(FRAC_BITS + 1) : 1;
    localparam int FW = FRAC_BITS + 1;

    logic            r_busy, n_busy;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [MV_W-1:0] r_rem, n_rem;
    logic [MV_W-1:0] r_den, n_den;
    logic [QW-1:0]   r_quo, n_quo;
    logic [MV_W:0]   s_shift;
    logic            s_last;

    assign s_shift = {r_rem, 1'b0};
    assign s_last  = (r_cnt == CW'(FRAC_BITS));

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quo  = '0;
        end else if (r_busy) begin
            if (s_last) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + CW'(1);
                // The remainder stays below den, so one compare and subtract per bit.
                if (s_shift >= {1'b0, r_den}) begin
                    n_rem = MV_W'(s_shift - {1'b0, r_den});
                    n_quo = QW'({r_quo, 1'b1});
                end else begin
                    n_rem = MV_W'(s_shift);
                    n_quo = QW'({r_quo, 1'b0});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_busy && s_last;
    // A nonzero remainder rounds the quotient up.
    assign o_frac = FW'(r_quo) + FW'(r_rem != '0);

endmodule

`default_nettype wire

@@ design/sensor_voltage_table_linearizer_core.sv @@
// Top level of the sensor voltage to temperature linearizer.
//
// i_mv carries one word per conversion: the sensor voltage in millivolts.
// o_temp carries one word back: the temperature in degrees Celsius with
// FRAC_BITS fraction bits, two's complement, floored. Both channels move a
// word on a clock edge where valid and ready are high.
// After reset the breakpoint RAM is loaded from the constant table, one
// entry per cycle; i_mv stays not ready until the last entry is written.
// A word is then handled one at a time: a binary search over the RAM takes
// at most ceil(log2(N+1)) steps, each a registered read then a compare,
// followed by two breakpoint reads and a bit-serial divider that
// produces one fraction bit per cycle. Inputs outside the table skip the
// reads and the divider. i_mv is ready again in the cycle after a result
// is loaded into the output register.
// The result sits in an output register, so a new word is taken while an
// earlier result waits; if the receiver stalls, the next result waits in
// the core until the register is free.
`default_nettype none
`include "sensor_voltage_table_linearizer_core_macros.svh"

module sensor_voltage_table_linearizer_core import svtl_pkg::*; #(
    parameter int TABLE_POINTS = 201,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    svtl_mv_if.sink      i_mv,
    svtl_temp_if.source  o_temp
);

    localparam int N  = (TABLE_POINTS > ROM_SIZE) ? ROM_SIZE :
                        ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
    localparam int AW = $clog2(N);
    localparam int IW = $clog2(N + 1);

    t_state r_state, n_state;

    logic [AW-1:0]          r_fill_addr, n_fill_addr;
    logic [MV_W-1:0]        r_mv, n_mv;
    logic [IW-1:0]          r_lo, n_lo;
    logic [IW-1:0]          r_hi, n_hi;
    logic [IW-1:0]          r_mid, n_mid;
    logic [IW-1:0]          r_hit, n_hit;
    logic [MV_W-1:0]        r_lo_mv, n_lo_mv;
    logic [TEMP_W-1:0]      r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    logic [TEMP_W-1:0]      r_out_temp, n_out_temp;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [MV_W-1:0]        ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [MV_W-1:0]        ram_rdata;

    t_div_req               div_req;
    logic                   div_done;
    logic [FRAC_BITS:0]     div_frac;

    logic [IW:0]            s_sum;
    logic [IW-1:0]          s_mid;
    logic                   s_in_acc;
    logic                   s_out_free;
    logic                   s_edge_lo;
    logic                   s_edge_hi;
    logic signed [31:0]     s_edge_val;
    logic signed [31:0]     s_interp_val;

    assign s_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign s_mid      = s_sum[IW:1];
    assign s_in_acc   = i_mv.valid && i_mv.ready;
    assign s_out_free = !r_out_valid || o_temp.ready;
    assign s_edge_lo  = (r_hit == '0);
    assign s_edge_hi  = (r_hit == IW'(N));

    // Outside the table the result is the temperature of the nearest end point.
    assign s_edge_val   = s_edge_lo ? (32'(TOP_TEMP) <<< FRAC_BITS)
                                    : ((32'(TOP_TEMP) - 32'(N - 1)) <<< FRAC_BITS);
    assign s_interp_val = ((32'(TOP_TEMP + 1) - 32'(r_hit)) <<< FRAC_BITS)
                          - 32'(div_frac);

    svtl_ram #(
        .WIDTH (MV_W),
        .DEPTH (N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    svtl_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_frac  (div_frac)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (r_fill_addr == AW'(N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_in_acc) begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (r_lo != r_hi) begin
                    n_state = ST_CMP;
                end else if (r_lo == '0 || r_lo == IW'(N)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_RD_LO;
                end
            end
            ST_CMP:      n_state = ST_SRCH;
            ST_RD_LO:    n_state = ST_RD_HI;
            ST_RD_HI:    n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_FILL;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_fill_addr  = r_fill_addr;
        n_mv         = r_mv;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_hit        = r_hit;
        n_lo_mv      = r_lo_mv;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !o_temp.ready;
        n_out_temp   = r_out_temp;
        ram_we       = 1'b0;
        ram_waddr    = r_fill_addr;
        ram_wdata    = rom_mv(8'(r_fill_addr));
        ram_raddr    = AW'(s_mid);
        div_req      = '0;
        div_req.num  = r_mv - r_lo_mv;
        div_req.den  = ram_rdata - r_lo_mv;
        i_mv.ready   = 1'b0;
        case (r_state)
            ST_FILL: begin
                ram_we      = 1'b1;
                n_fill_addr = r_fill_addr + AW'(1);
            end
            ST_IDLE: begin
                i_mv.ready = 1'b1;
                n_mv       = i_mv.millivolts;
                n_lo       = '0;
                n_hi       = IW'(N);
            end
            ST_SRCH: begin
                n_mid = s_mid;
                n_hit = r_lo;
            end
            ST_CMP: begin
                // First breakpoint strictly above the input bounds the segment.
                if (ram_rdata > r_mv) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + IW'(1);
                end
            end
            ST_RD_LO: begin
                ram_raddr = AW'(r_hit - IW'(1));
            end
            ST_RD_HI: begin
                n_lo_mv   = ram_rdata;
                ram_raddr = AW'(r_hit);
            end
            ST_DIV_GO: begin
                div_req.start = 1'b1;
            end
            ST_DIV_WAIT: begin
                n_res = s_interp_val[TEMP_W-1:0];
            end
            ST_OUT: begin
                if (s_edge_lo || s_edge_hi) begin
                    n_res = s_edge_val[TEMP_W-1:0];
                end
                if (s_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = (s_edge_lo || s_edge_hi) ? s_edge_val[TEMP_W-1:0] : r_res;
                end
            end
            default: begin
                n_fill_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_addr <= n_fill_addr;
            r_out_valid <= n_out_valid;
        end
        r_mv       <= n_mv;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_hit      <= n_hit;
        r_lo_mv    <= n_lo_mv;
        r_res      <= n_res;
        r_out_temp <= n_out_temp;
    end

    assign o_temp.valid          = r_out_valid;
    assign o_temp.temperature_q8 = signed'(r_out_temp);

    `SVTL_ASSERT_NOW(a_search_bounds, (r_state == ST_SRCH || r_state == ST_CMP), (r_lo <= r_hi), "search bounds crossed")
    `SVTL_ASSERT_NOW(a_interior_segment, (r_state == ST_RD_LO), (r_hit != '0 && r_hit != IW'(N)), "interpolation started outside the table")
    `SVTL_ASSERT_NOW(a_div_operands, (r_state == ST_DIV_GO), (div_req.num < div_req.den), "segment does not contain the input")
    `SVTL_ASSERT_NOW(a_div_done_owner, div_done, (r_state == ST_DIV_WAIT), "divider finished with no conversion waiting")
    `SVTL_ASSERT_NEXT(a_search_init, (r_state == ST_IDLE && s_in_acc), (r_lo == '0 && r_hi == IW'(N)), "search not reset on a new word")

endmodule

`default_nettype wire

@@ sim/sensor_voltage_table_linearizer_core_checker.sv @@
// Checker that predicts the temperature for every accepted voltage word and compares results.
`default_nettype none

module sensor_voltage_table_linearizer_core_checker import svtl_pkg::*; #(
    parameter int TABLE_POINTS = 201,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    svtl_mv_if        mv_bus,
    svtl_temp_if      temp_bus,
    output int        o_pending,
    output int        o_fail_count,
    output int        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [MV_W-1:0]          mv;
        logic signed [TEMP_W-1:0] temp;
    } t_temp_expect;

    t_temp_expect expected_temps [$];
    t_temp_expect oldest;
    int           mismatches = 0;
    int           compared   = 0;
    int           waiting    = 0;

    assign o_pending    = waiting;
    assign o_fail_count = mismatches;
    assign o_checked    = compared;

    // Floored linear interpolation between the two breakpoints around the voltage.
    function automatic logic signed [TEMP_W-1:0] temperature_from_mv(input logic [MV_W-1:0] mv);
        int     points;
        int     hit;
        longint one_deg;
        longint lo_mv;
        longint span;
        longint frac;
        longint whole;
        points  = TABLE_POINTS;
        one_deg = longint'(1) << FRAC_BITS;
        if (points > ROM_SIZE) begin
            points = ROM_SIZE;
        end
        if (points < 2) begin
            points = 2;
        end
        hit = points;
        for (int k = 0; k < points; k++) begin
            if (hit == points && VOLT_ROM[k] > mv) begin
                hit = k;
            end
        end
        if (hit == 0) begin
            whole = longint'(TOP_TEMP) * one_deg;
        end else if (hit == points) begin
            whole = longint'(TOP_TEMP - (points - 1)) * one_deg;
        end else begin
            lo_mv = longint'(VOLT_ROM[hit-1]);
            span  = longint'(VOLT_ROM[hit]) - lo_mv;
            // Rounding the fraction up makes the subtraction a floor.
            frac  = (((longint'(mv) - lo_mv) << FRAC_BITS) + span - 1) / span;
            whole = longint'(TOP_TEMP - (hit - 1)) * one_deg - frac;
        end
        return whole[TEMP_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // The result word leaves before the new voltage word is queued, since a
    // word accepted this cycle cannot produce its result in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (temp_bus.valid && temp_bus.ready) begin
                if (expected_temps.size() == 0) begin
                    report_mismatch($sformatf("temperature word %0d with no voltage waiting",
                                              temp_bus.temperature_q8));
                end else begin
                    oldest = expected_temps.pop_front();
                    compared++;
                    if (temp_bus.temperature_q8 !== oldest.temp) begin
                        report_mismatch($sformatf("%0d mV gave temperature %0d, expected %0d",
                                                  oldest.mv, temp_bus.temperature_q8,
                                                  oldest.temp));
                    end
                end
            end
            if (mv_bus.valid && mv_bus.ready) begin
                expected_temps.push_back('{mv_bus.millivolts,
                                           temperature_from_mv(mv_bus.millivolts)});
            end
            waiting = expected_temps.size();
        end
    end

endmodule

`default_nettype wire

@@ sim/sensor_voltage_table_linearizer_core_tb.sv @@
// Top of the linearizer testbench: clock, reset, voltage stimulus, output stalls and verdict.
`default_nettype none

module sensor_voltage_table_linearizer_core_tb import svtl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_POINTS  = 201;
    localparam int FRAC_BITS     = 8;
    localparam int RANDOM_WORDS  = 550;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 60;

    localparam logic [MV_W-1:0] CORNER_MV [20] = '{
        11'd0,    11'd1,    11'd300,  11'd301,  11'd302,
        11'd309,  11'd310,  11'd1023, 11'd1024, 11'd1364,
        11'd1365, 11'd1366, 11'd1566, 11'd1567, 11'd1920,
        11'd1954, 11'd1955, 11'd1956, 11'd2046, 11'd2047
    };

    logic i_clk;
    logic i_rst_n;

    svtl_mv_if   mv_ch ();
    svtl_temp_if temp_ch ();

    int  pending;
    int  fail_count;
    int  checked;
    bit  no_idle       = 1'b0;
    bit  hold_off_req  = 1'b0;
    int  holds_done    = 0;
    int  words_sent    = 0;
    int  on_breakpoint = 0;
    int  off_table     = 0;

    sensor_voltage_table_linearizer_core #(
        .TABLE_POINTS (TABLE_POINTS),
        .FRAC_BITS    (FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mv    (mv_ch),
        .o_temp  (temp_ch)
    );

    sensor_voltage_table_linearizer_core_checker #(
        .TABLE_POINTS (TABLE_POINTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .mv_bus       (mv_ch),
        .temp_bus     (temp_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [MV_W-1:0] random_reading();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            off_table++;
            return MV_W'($urandom_range(0, 300));
        end else if (r < 16) begin
            off_table++;
            return MV_W'($urandom_range(1955, 2047));
        end else if (r < 26) begin
            on_breakpoint++;
            return VOLT_ROM[$urandom_range(0, ROM_SIZE - 1)];
        end
        return MV_W'($urandom_range(301, 1954));
    endfunction

    // Called and left at a falling edge; valid stays high between back-to-back words.
    task automatic send_reading(input logic [MV_W-1:0] mv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            mv_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        mv_ch.valid      <= 1'b1;
        mv_ch.millivolts <= mv;
        do begin
            @(posedge i_clk);
        end while (!mv_ch.ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int gap;
        temp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req   = 1'b0;
                temp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                holds_done++;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    temp_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            temp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    initial begin
        mv_ch.valid      = 1'b0;
        mv_ch.millivolts = '0;
        i_rst_n          = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (CORNER_MV[k]) begin
            send_reading(CORNER_MV[k]);
        end

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            // The sender keeps offering words during each hold-off so the core backs up.
            if (k == 100 || k == 420) begin
                hold_off_req = 1'b1;
            end
            if (k == 200) begin
                no_idle = 1'b1;
            end
            if (k == 300) begin
                no_idle = 1'b0;
            end
            send_reading(random_reading());
        end
        mv_ch.valid <= 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d voltage words (%0d corner values, %0d on breakpoints, %0d off table).",
                 words_sent, $size(CORNER_MV), on_breakpoint, off_table);
        $display("Compared %0d temperatures across %0d long output hold-offs, %0d mismatches.",
                 checked, holds_done, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d temperatures still outstanding.", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
